// ----- hdl/ftt_pkg.sv -----
`default_nettype none

package ftt_pkg;

  // widths fixed by the request and result fields
  localparam int unsigned CfgW   = 7;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned PortW  = 16;
  localparam int unsigned HostW  = 16;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned StatW  = 2;

  localparam logic [CfgW-1:0] CfgReset = 7'd64;

  // request kinds
  localparam logic ReqCreate = 1'b0;
  localparam logic ReqLookup = 1'b1;

  // result status codes
  localparam logic [StatW-1:0] StatOk       = 2'd0;
  localparam logic [StatW-1:0] StatFull     = 2'd1;
  localparam logic [StatW-1:0] StatNotFound = 2'd2;

  // request as it travels down the row of cells
  typedef struct packed {
    logic                 lookup;
    logic [2*AddrW-1:0]   addrs;
    logic [2*PortW-1:0]   ports;
    logic [HostW-1:0]     host;
    logic                 done;
    logic [IdxW-1:0]      index;
  } ftt_item_t;

endpackage

`default_nettype wire

// ----- hdl/ftt_cell.sv -----
`default_nettype none

module ftt_cell import ftt_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      advance_i,
  input  wire logic      active_i,
  input  wire logic      valid_i,
  input  wire ftt_item_t item_i,
  output logic           valid_o,
  output ftt_item_t      item_o
);

  logic                 valid_q;
  ftt_item_t            item_q, item_d;
  logic                 open_q;
  logic [2*AddrW-1:0]   addrs_q;
  logic [2*PortW-1:0]   ports_q;
  logic [HostW-1:0]     host_q;
  logic                 live, hit_free, hit_match;

  // local decision for the passing request
  assign live      = valid_i && !item_i.done && active_i;
  assign hit_free  = live && (item_i.lookup == ReqCreate) && !open_q;
  assign hit_match = live && (item_i.lookup == ReqLookup) && open_q &&
                     (addrs_q == item_i.addrs) && (ports_q == item_i.ports);

  // result so far, handed to the next cell
  always_comb begin
    item_d = item_i;
    if (hit_free || hit_match) begin
      item_d.done  = 1'b1;
      item_d.index = IdxW'(CELL_IDX);
    end
    if (hit_match) begin
      item_d.host = host_q;
    end
  end

  // stage valid and entry open flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      open_q  <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
      if (hit_free) begin
        open_q <= 1'b1;
      end
    end
  end

  // stage payload and entry contents
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      item_q <= item_d;
      if (hit_free) begin
        addrs_q <= item_i.addrs;
        ports_q <= item_i.ports;
        host_q  <= item_i.host;
      end
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  // an open entry never closes again
  a_open_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |=> open_q)
    else $error("entry closed after being opened");

  // a request already served passes through untouched
  a_done_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && valid_i && item_i.done |=> item_q == $past(item_i))
    else $error("served request altered by cell");

  // an entry opens only for a create that found it closed
  a_open_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(open_q) |-> $past(hit_free && advance_i))
    else $error("entry opened without a create");

endmodule

`default_nettype wire

// ----- hdl/flow_tuple_table_core.sv -----
// a request passes the row of cells in order, from request accept to result valid
// throughput: one request per cycle while the output is not stalled; each cell of the row holds one entry and one stage
// a stalled result freezes the whole row, so in_ready_o follows the output side
// reset: all entries closed, row empty, entries_in_use back to 64
// entry contents are not cleared; no sweep after reset
`default_nettype none

module flow_tuple_table_core import ftt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               req_type_i,
  input  wire logic [AddrW-1:0]   src_addr_i,
  input  wire logic [AddrW-1:0]   dst_addr_i,
  input  wire logic [PortW-1:0]   src_port_i,
  input  wire logic [PortW-1:0]   dst_port_i,
  input  wire logic [HostW-1:0]   host_id_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [StatW-1:0]        status_o,
  output logic [IdxW-1:0]         entry_index_o,
  output logic [HostW-1:0]        entry_host_id_o
);

  logic [CfgW-1:0]    entries_in_use_q;
  logic               advance;
  logic [MAX_ENTRIES:0] valid_w;
  ftt_item_t          item_w [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] active;
  ftt_item_t          head;
  ftt_item_t          last;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_in_use_q <= CfgReset;
    end else if (cfg_we_i) begin
      entries_in_use_q <= cfg_wdata_i;
    end
  end

  // row moves unless the finished result is held
  assign advance    = !(valid_w[MAX_ENTRIES] && !out_ready_i);
  assign in_ready_o = advance;

  // new request enters the first cell
  assign valid_w[0] = in_valid_i;
  always_comb begin
    head.lookup = req_type_i;
    head.addrs  = {src_addr_i, dst_addr_i};
    head.ports  = {src_port_i, dst_port_i};
    head.host   = host_id_i;
    head.done   = 1'b0;
    head.index  = '0;
  end
  assign item_w[0] = head;

  // row of entry cells
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    assign active[g] = (32'(entries_in_use_q) > 32'(g));
    ftt_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .active_i  (active[g]),
      .valid_i   (valid_w[g]),
      .item_i    (item_w[g]),
      .valid_o   (valid_w[g+1]),
      .item_o    (item_w[g+1])
    );
  end

  // result formatting from the last stage
  assign last        = item_w[MAX_ENTRIES];
  assign out_valid_o = valid_w[MAX_ENTRIES];
  always_comb begin
    if (last.done) begin
      status_o        = StatOk;
      entry_index_o   = last.index;
      entry_host_id_o = last.host;
    end else begin
      status_o        = (last.lookup == ReqLookup) ? StatNotFound : StatFull;
      entry_index_o   = '0;
      entry_host_id_o = '0;
    end
  end

  // failed requests report zero index and host
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StatOk) |-> (entry_index_o == '0) && (entry_host_id_o == '0))
    else $error("nonzero index or host on failed request");

  // full only for create, not found only for lookup
  a_status_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StatOk) ||
                    ((status_o == StatFull) && (last.lookup == ReqCreate)) ||
                    ((status_o == StatNotFound) && (last.lookup == ReqLookup)))
    else $error("status does not fit request kind");

  // while held, the first stage keeps its request
  a_row_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(valid_w[1]))
    else $error("row moved while output stalled");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ftt_pkg::*;

  localparam int unsigned NumEntries = 64;
  localparam int unsigned PoolMax    = 48;
  localparam int unsigned DrainWait  = 2 * NumEntries + 8;

  // four-tuple that keys an entry
  typedef struct packed {
    logic [AddrW-1:0] src_addr;
    logic [AddrW-1:0] dst_addr;
    logic [PortW-1:0] src_port;
    logic [PortW-1:0] dst_port;
  } flow_key_t;

  typedef struct packed {
    logic             kind;
    flow_key_t        key;
    logic [HostW-1:0] host;
  } flow_req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [IdxW-1:0]  index;
    logic [HostW-1:0] host;
  } flow_result_t;

  typedef enum int {PaceNone, PaceSend, PaceRecv, PaceBoth} pace_e;

  localparam flow_key_t KeyZero = '0;
  localparam flow_key_t KeyOnes = '1;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CfgW-1:0]  cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             req_type = 1'b0;
  logic [AddrW-1:0] src_addr = '0;
  logic [AddrW-1:0] dst_addr = '0;
  logic [PortW-1:0] src_port = '0;
  logic [PortW-1:0] dst_port = '0;
  logic [HostW-1:0] host_id = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [StatW-1:0] status;
  logic [IdxW-1:0]  entry_index;
  logic [HostW-1:0] entry_host_id;

  // shadow of the table contents and the entry count
  logic             tbl_open [NumEntries];
  logic [2*AddrW-1:0] tbl_addrs [NumEntries];
  logic [2*PortW-1:0] tbl_ports [NumEntries];
  logic [HostW-1:0] tbl_host [NumEntries];
  logic [CfgW-1:0]  tbl_limit = CfgReset;

  flow_req_t    pending_reqs [$];
  flow_result_t expected_results [$];
  flow_key_t    key_pool [$];
  flow_req_t    req_cur;
  bit           req_taken = 1'b0;
  pace_e        pace = PaceNone;
  int           hold_cycles = 0;

  int err_count = 0;
  int n_reqs = 0;
  int n_results = 0;
  int n_created = 0;
  int n_full = 0;
  int n_hits = 0;
  int n_misses = 0;

  flow_tuple_table_core #(
    .MAX_ENTRIES(NumEntries)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .src_addr_i     (src_addr),
    .dst_addr_i     (dst_addr),
    .src_port_i     (src_port),
    .dst_port_i     (dst_port),
    .host_id_i      (host_id),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .entry_index_o  (entry_index),
    .entry_host_id_o(entry_host_id)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table behavior: create takes lowest closed entry, lookup finds lowest open match
  function automatic flow_result_t flow_table_apply(flow_req_t r);
    flow_result_t res;
    int unsigned lim;
    logic [2*AddrW-1:0] addrs;
    logic [2*PortW-1:0] ports;
    lim = (tbl_limit > NumEntries) ? NumEntries : tbl_limit;
    addrs = {r.key.src_addr, r.key.dst_addr};
    ports = {r.key.src_port, r.key.dst_port};
    res.status = (r.kind == ReqLookup) ? StatNotFound : StatFull;
    res.index = '0;
    res.host = '0;
    for (int unsigned i = 0; i < lim; i++) begin
      if (r.kind == ReqLookup) begin
        if (tbl_open[i] && tbl_addrs[i] == addrs && tbl_ports[i] == ports) begin
          res.status = StatOk;
          res.index = i[IdxW-1:0];
          res.host = tbl_host[i];
          break;
        end
      end else if (!tbl_open[i]) begin
        tbl_open[i] = 1'b1;
        tbl_addrs[i] = addrs;
        tbl_ports[i] = ports;
        tbl_host[i] = r.host;
        res.status = StatOk;
        res.index = i[IdxW-1:0];
        res.host = r.host;
        break;
      end
    end
    return res;
  endfunction

  function automatic flow_key_t rand_key();
    flow_key_t k;
    k.src_addr = $urandom();
    k.dst_addr = $urandom();
    k.src_port = 16'($urandom_range(16'hffff));
    k.dst_port = 16'($urandom_range(16'hffff));
    return k;
  endfunction

  // one bit off in one field: a near miss
  function automatic flow_key_t key_flip(flow_key_t k);
    int unsigned b;
    case ($urandom_range(3))
      0: begin
        b = $urandom_range(AddrW - 1);
        k.src_addr = k.src_addr ^ (32'd1 << b);
      end
      1: begin
        b = $urandom_range(AddrW - 1);
        k.dst_addr = k.dst_addr ^ (32'd1 << b);
      end
      2: begin
        b = $urandom_range(PortW - 1);
        k.src_port = k.src_port ^ (16'd1 << b);
      end
      default: begin
        b = $urandom_range(PortW - 1);
        k.dst_port = k.dst_port ^ (16'd1 << b);
      end
    endcase
    return k;
  endfunction

  function automatic flow_key_t pool_key();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  // mostly known tuples so that creates duplicate and lookups hit
  function automatic flow_req_t rand_req();
    flow_req_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.host = 16'($urandom_range(16'hffff));
    if (pick < 20) begin
      r.kind = ReqCreate;
      if ($urandom_range(1)) begin
        r.key = pool_key();
      end else begin
        r.key = rand_key();
        if (key_pool.size() < PoolMax) key_pool.push_back(r.key);
        else key_pool[$urandom_range(PoolMax - 1)] = r.key;
      end
    end else begin
      r.kind = ReqLookup;
      if (pick < 70) r.key = pool_key();
      else if (pick < 90) r.key = key_flip(pool_key());
      else r.key = rand_key();
    end
    return r;
  endfunction

  function automatic void queue_req(logic kind, flow_key_t key, logic [HostW-1:0] host);
    flow_req_t r;
    r.kind = kind;
    r.key = key;
    r.host = host;
    pending_reqs.push_back(r);
  endfunction

  function automatic bit pace_gap(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      req_taken = 1'b0;
      if (pending_reqs.size() != 0 &&
          !pace_gap(pace == PaceSend ? 65 : (pace == PaceBoth ? 15 : 0))) begin
        req_cur = pending_reqs.pop_front();
        req_type <= req_cur.kind;
        src_addr <= req_cur.key.src_addr;
        dst_addr <= req_cur.key.dst_addr;
        src_port <= req_cur.key.src_port;
        dst_port <= req_cur.key.dst_port;
        host_id <= req_cur.host;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side ready, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !pace_gap(pace == PaceRecv ? 65 : (pace == PaceBoth ? 15 : 0));
    end
  end

  // accepted request: predict its result
  always @(posedge clk) begin
    flow_result_t res;
    if (rst_n && in_valid && in_ready) begin
      req_taken = 1'b1;
      res = flow_table_apply(req_cur);
      expected_results.push_back(res);
      n_reqs++;
      if (res.status == StatFull) n_full++;
      else if (res.status == StatNotFound) n_misses++;
      else if (req_cur.kind == ReqCreate) n_created++;
      else n_hits++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    flow_result_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: status %0d index %0d host %h",
                   status, entry_index, entry_host_id);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || entry_index !== want.index ||
            entry_host_id !== want.host) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch on result %0d: status %0d/%0d index %0d/%0d host %h/%h",
                     n_results, want.status, status, want.index, entry_index,
                     want.host, entry_host_id);
        end
      end
    end
  end

  // all queued requests sent and every result back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_limit(input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    tbl_limit = val;
  endtask

  task automatic run_random(input logic [CfgW-1:0] lim, input pace_e mode, input int n,
                            input int hold, input bit split);
    write_limit(lim);
    pace = mode;
    hold_cycles = hold;
    for (int i = 0; i < n; i++) begin
      // sender pause until the table has answered everything
      if (split && i == n / 2) wait_drained();
      pending_reqs.push_back(rand_req());
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < NumEntries; i++) tbl_open[i] = 1'b0;
    key_pool.push_back(KeyZero);
    key_pool.push_back(KeyOnes);
    for (int i = 0; i < 10; i++) key_pool.push_back(rand_key());

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero entries in use: nothing searched or allocated
    write_limit(7'd0);
    queue_req(ReqCreate, KeyOnes, 16'hffff);
    queue_req(ReqLookup, KeyZero, 16'h0000);
    wait_drained();

    // a single entry: one create, then full
    write_limit(7'd1);
    queue_req(ReqLookup, KeyZero, 16'h0000);
    queue_req(ReqCreate, KeyZero, 16'h0000);
    queue_req(ReqCreate, KeyOnes, 16'hffff);
    queue_req(ReqLookup, KeyZero, 16'hffff);
    queue_req(ReqLookup, KeyOnes, 16'h0000);
    wait_drained();

    // count above the table size saturates; duplicates and near misses
    write_limit(7'd127);
    queue_req(ReqCreate, KeyOnes, 16'hffff);
    queue_req(ReqCreate, KeyOnes, 16'h1234);
    queue_req(ReqLookup, KeyOnes, 16'h0000);
    queue_req(ReqLookup, KeyZero, 16'habcd);
    for (int i = 0; i < 4; i++) queue_req(ReqLookup, key_flip(KeyOnes), 16'h0000);
    queue_req(ReqLookup, key_flip(KeyZero), 16'h0000);
    wait_drained();

    // lowered count hides entries above it, raising it brings them back
    write_limit(7'd1);
    queue_req(ReqLookup, KeyOnes, 16'h0000);
    queue_req(ReqCreate, KeyOnes, 16'h5555);
    wait_drained();
    write_limit(7'd64);
    queue_req(ReqLookup, KeyOnes, 16'h0000);
    wait_drained();

    // random traffic over several counts and pacing patterns
    run_random(7'd5, PaceNone, 150, 0, 1'b0);
    run_random(7'd40, PaceSend, 200, 0, 1'b0);
    run_random(7'd20, PaceRecv, 200, 0, 1'b0);
    run_random(7'd64, PaceBoth, 250, 0, 1'b0);
    run_random(7'd127, PaceNone, 250, 400, 1'b0);
    run_random(7'd64, PaceSend, 250, 0, 1'b1);
    run_random(7'd3, PaceRecv, 150, 0, 1'b0);
    run_random(7'd100, PaceBoth, 200, 0, 1'b0);
    run_random(7'd64, PaceNone, 200, 0, 1'b0);

    wait_drained();
    repeat (DrainWait) @(posedge clk);

    $display("covered %0d requests: %0d creates stored, %0d refused as full,",
             n_reqs, n_created, n_full);
    $display("%0d lookups matched and %0d not found, %0d errors",
             n_hits, n_misses, err_count);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
